// ----- design/bqf_pkg.sv -----
// Shared types, constants and the microcode program of the biquad filter.
// No dependencies; used by biquad_tdf2_filter.

package bqf_pkg;

	// fixed formats
	localparam int COEF_W          = 32;   // coefficient register width
	localparam int STATE_W         = 48;   // state / y width
	localparam int STATE_FRAC      = 39;   // fraction bits of state and y
	localparam int NUM_COEF        = 5;
	localparam int Y_LO_W          = 24;   // low slice of y fed to the multiplier
	localparam int CFG_IDX_W       = 3;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_COEF_FRAC   = 28;

	// step counter
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN_2 = 3'd4;

	// multiplier A operand
	typedef enum logic [1:0] {
		MA_X,
		MA_YLO,
		MA_YHI
	} mul_a_t;

	// coefficient select, same order as the register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		C_B0 = REG_FF_GAIN_0,
		C_B1 = REG_FF_GAIN_1,
		C_B2 = REG_FF_GAIN_2,
		C_A1 = REG_FB_GAIN_1,
		C_A2 = REG_FB_GAIN_2
	} coef_sel_t;

	// product register operation
	typedef enum logic [1:0] {
		P_HOLD,
		P_LOAD_X,   // sample product, aligned to state scale
		P_LOAD,     // low partial product of y
		P_ADD_HI    // add high partial product of y, weighted by 2^24
	} prod_op_t;

	// accumulator operation (T = product floor-shifted to state scale)
	typedef enum logic [2:0] {
		A_HOLD,
		A_D1_ADD,   // acc = delay_one + T
		A_D2_ADD,   // acc = delay_two + T
		A_ZERO_ADD, // acc = T
		A_SUB       // acc = acc - T
	} acc_op_t;

	// saturated write-back target
	typedef enum logic [1:0] {
		W_NONE,
		W_Y,
		W_D1,
		W_D2
	} wr_t;

	// sequencing
	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_WAIT_IN, // hold until an input beat is taken
		SQ_EMIT     // hold until the output slot is free, then jump
	} seq_t;

	typedef struct packed {
		mul_a_t    mul_a;
		coef_sel_t coef;
		prod_op_t  prod_op;
		acc_op_t   acc_op;
		wr_t       wr;
		seq_t      seq;
		step_t     jump;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		mul_a: MA_X, coef: C_B0, prod_op: P_HOLD, acc_op: A_HOLD,
		wr: W_NONE, seq: SQ_NEXT, jump: '0
	};

	// Microcode. Operands feed the registered multiplier, whose result loads the
	// product register, which feeds the accumulator; each lands in the step after its source.
	function automatic ctl_t ucode(input step_t step);
		ctl_t c;
		c = CTL_NOP;
		case (step)
			4'd1: begin
				c.mul_a = MA_X;   c.coef = C_B0;
			end
			4'd2: begin
				c.mul_a = MA_X;   c.coef = C_B1;
				c.prod_op = P_LOAD_X;
			end
			4'd3: begin
				c.prod_op = P_LOAD_X;
				c.acc_op  = A_D1_ADD;   // y = b0*x + d1
			end
			4'd4: begin
				c.wr     = W_Y;
				c.acc_op = A_D2_ADD;    // start n1 = b1*x + d2
			end
			4'd5: begin
				c.mul_a = MA_YLO; c.coef = C_A1;
			end
			4'd6: begin
				c.mul_a = MA_YHI; c.coef = C_A1;
				c.prod_op = P_LOAD;
			end
			4'd7: begin
				c.mul_a = MA_X;   c.coef = C_B2;
				c.prod_op = P_ADD_HI;
			end
			4'd8: begin
				c.mul_a = MA_YLO; c.coef = C_A2;
				c.prod_op = P_LOAD_X;
				c.acc_op  = A_SUB;      // n1 -= a1*y
			end
			4'd9: begin
				c.mul_a = MA_YHI; c.coef = C_A2;
				c.prod_op = P_LOAD;
				c.wr      = W_D1;
				c.acc_op  = A_ZERO_ADD; // start n2 = b2*x
			end
			4'd10: begin
				c.prod_op = P_ADD_HI;
			end
			4'd11: begin
				c.acc_op = A_SUB;       // n2 -= a2*y
			end
			4'd12: begin
				c.wr   = W_D2;
				c.seq  = SQ_EMIT;
				c.jump = '0;
			end
			default: begin
				c.seq = SQ_WAIT_IN;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- design/biquad_tdf2_filter.sv -----
// Biquad IIR filter, transposed direct form II, microcoded over one shared
// multiplier. Depends on bqf_pkg (types, constants, microcode table).
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata: sample_in
// m_*       out  m_tvalid / m_tready  m_tdata: sample_out, m_tuser: clipped
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (coefficients)
//
// Each sample runs one accept step and twelve microcode steps on the single
// 25-by-32-bit multiplier (seven products, y products in two halves). The
// next sample is taken the cycle after the result is loaded.
// Reset clears state, coefficients and the sequencer. A stalled output holds
// the last step until the output register is free; input waits meanwhile.

module biquad_tdf2_filter
	import bqf_pkg::*;
#(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_in
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // sample_out
	output logic                                m_tuser,  // clipped
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [COEF_W-1:0]                   cfg_data
);

	localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int UP      = STATE_FRAC + 1 - SAMPLE_BITS; // sample alignment
	localparam int MA_W    = (SAMPLE_BITS > Y_LO_W + 1) ? SAMPLE_BITS : Y_LO_W + 1;
	localparam int MUL_W   = MA_W + COEF_W;
	localparam int PROD_W  = STATE_W + COEF_W;
	localparam int TERM_W  = PROD_W - COEF_FRAC_BITS;
	localparam int ACC_W   = TERM_W + 2;
	localparam int RND_W   = STATE_W + 1;

	localparam logic signed [ACC_W-1:0] ST_MAX =
		{{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
	localparam logic signed [RND_W-1:0] O_MAX =
		{{(RND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RND_W-1:0] O_MIN = ~O_MAX;
	localparam logic signed [RND_W-1:0] HALF  = RND_W'(1) <<< (UP - 1);

	// registers
	step_t                     step_q;
	logic signed [COEF_W-1:0]  coef_q [NUM_COEF];
	logic signed [STATE_W-1:0] d1_q, d2_q, y_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [MUL_W-1:0]   mul_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      clip_q;
	logic [SAMPLE_BITS-1:0]    out_q;

	// control
	ctl_t ctl;
	logic step_go, out_load, in_take;

	assign ctl       = ucode(step_q);
	assign s_tready  = (ctl.seq == SQ_WAIT_IN);
	assign cfg_ready = 1'b1;
	assign in_take   = s_tvalid && s_tready;

	always_comb begin
		case (ctl.seq)
			SQ_NEXT:    step_go = 1'b1;
			SQ_WAIT_IN: step_go = s_tvalid;
			SQ_EMIT:    step_go = !m_tvalid || m_tready;
			default:    step_go = 1'b0;
		endcase
	end
	assign out_load = (ctl.seq == SQ_EMIT) && step_go;

	// step counter with jump on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (step_go) begin
			if (ctl.seq == SQ_EMIT) begin
				step_q <= ctl.jump;
			end else begin
				step_q <= step_t'(step_q + 1'b1);
			end
		end
	end

	// coefficient registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_COEF))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// multiplier operand A
	logic signed [MA_W-1:0] mul_a;
	always_comb begin
		case (ctl.mul_a)
			MA_X:    mul_a = MA_W'(x_q);
			MA_YLO:  mul_a = MA_W'($signed({1'b0, y_q[Y_LO_W-1:0]}));
			MA_YHI:  mul_a = MA_W'($signed(y_q[STATE_W-1:Y_LO_W]));
			default: mul_a = '0;
		endcase
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		mul_q <= MUL_W'(mul_a) * MUL_W'(coef_q[ctl.coef]);
	end

	// product register: exact product at coefficient scale
	always_ff @(posedge clk) begin
		case (ctl.prod_op)
			P_LOAD_X: prod_q <= PROD_W'(mul_q) <<< UP;
			P_LOAD:   prod_q <= PROD_W'(mul_q);
			P_ADD_HI: prod_q <= prod_q + (PROD_W'(mul_q) <<< Y_LO_W);
			default:  prod_q <= prod_q;
		endcase
	end

	// floor shift to state scale, then accumulate
	logic signed [ACC_W-1:0] term;
	assign term = ACC_W'($signed(prod_q[PROD_W-1:COEF_FRAC_BITS]));

	always_ff @(posedge clk) begin
		case (ctl.acc_op)
			A_D1_ADD:   acc_q <= ACC_W'(d1_q) + term;
			A_D2_ADD:   acc_q <= ACC_W'(d2_q) + term;
			A_ZERO_ADD: acc_q <= term;
			A_SUB:      acc_q <= acc_q - term;
			default:    acc_q <= acc_q;
		endcase
	end

	// saturate accumulator to 48 bits
	logic                      acc_sat;
	logic signed [STATE_W-1:0] acc_48;
	always_comb begin
		acc_sat = 1'b1;
		if (acc_q > ST_MAX) begin
			acc_48 = STATE_W'(ST_MAX);
		end else if (acc_q < ST_MIN) begin
			acc_48 = STATE_W'(ST_MIN);
		end else begin
			acc_48  = STATE_W'(acc_q);
			acc_sat = 1'b0;
		end
	end

	// write-back of y and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (step_go) begin
			if (ctl.wr == W_D1) d1_q <= acc_48;
			if (ctl.wr == W_D2) d2_q <= acc_48;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) x_q <= $signed(s_tdata[SAMPLE_BITS-1:0]);
		if (step_go && (ctl.wr == W_Y)) y_q <= acc_48;
	end

	// clip flag over the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (in_take) begin
			clip_q <= 1'b0;
		end else if (step_go && (ctl.wr != W_NONE) && acc_sat) begin
			clip_q <= 1'b1;
		end
	end

	// output rounding: add half an LSB, floor, saturate
	logic signed [RND_W-1:0] rnd_sum, rnd_q;
	logic                    o_sat;
	logic [SAMPLE_BITS-1:0]  o_val;
	always_comb begin
		rnd_sum = RND_W'(y_q) + HALF;
		rnd_q   = rnd_sum >>> UP;
		o_sat   = 1'b1;
		if (rnd_q > O_MAX) begin
			o_val = SAMPLE_BITS'(O_MAX);
		end else if (rnd_q < O_MIN) begin
			o_val = SAMPLE_BITS'(O_MIN);
		end else begin
			o_val = SAMPLE_BITS'(rnd_q);
			o_sat = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q   <= o_val;
			m_tuser <= clip_q || acc_sat || o_sat;
		end
	end

	assign m_tdata = DATA_W'(out_q);

`ifndef SYNTHESIS
	// one item at a time: after an accept the input side closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten before it was taken");

	// after the result load the sequencer is back at the accept step
	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (s_tready && (step_q == '0)))
		else $error("sequencer did not return to the accept step");
`endif

endmodule
